@@ design/tplru_pkg.sv @@
package tplru_pkg;

  // set geometry
  localparam int WAYS      = 16;
  localparam int TAG_WIDTH = 32;
  localparam int LEVELS    = $clog2(WAYS);
  localparam int LEAVES    = 1 << LEVELS;
  localparam int NODE_W    = LEVELS + 1;
  localparam int CNT_W     = $clog2(LEVELS + 1);
  localparam int LINE_W    = TAG_WIDTH + 4;

  // mode codes
  localparam logic MODE_FILL  = 1'b0;
  localparam logic MODE_INVAL = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] tag;
    logic [2:0]  line_state;
    logic        line_dirty;
  } req_t;

  typedef struct packed {
    logic        victim_valid;
    logic [3:0]  victim_way;
    logic [31:0] victim_tag;
    logic [2:0]  victim_state;
    logic        victim_dirty;
  } rsp_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WALK  = 8'b0000_0010,
    S_FREAD = 8'b0000_0100,
    S_FDATA = 8'b0000_1000,
    S_SRCH  = 8'b0001_0000,
    S_SCMP  = 8'b0010_0000,
    S_PATH  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

endpackage

@@ design/tplru_ram.sv @@
module tplru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/tree_plru_way_replacer_top.sv @@
// Tree pseudo-LRU replacer for one cache set of WAYS lines. Each request item
// either fills a new line (mode 0) at the way the PLRU tree points to, flipping
// every tree bit on the way down, or invalidates the highest valid way whose
// tag matches (mode 1), pointing the tree away from it. Exactly one response
// item follows each request. The block takes one request at a time and holds
// req_ready low until the response is in its output register. A fill walks
// the tree one level per cycle, then reads and writes the line store. An
// invalidate scans from the highest way down, stepping past each empty way
// and, for each valid way, reading the line store and then comparing the
// tag; on a hit it updates the tree path level by level, then posts the
// response. Valid marks and tree bits clear at reset with no clearing
// pass.
module tree_plru_way_replacer_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  tplru_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output tplru_pkg::rsp_t   rsp
);
  import tplru_pkg::*;

  state_t                state;
  logic [LEAVES-1:1]     tree_bits;
  logic [WAYS-1:0]       way_valid;
  logic [NODE_W-1:0]     node;
  logic [CNT_W-1:0]      cnt;
  logic [LEVELS-1:0]     ptr;
  req_t                  item;
  rsp_t                  res;

  logic                  req_fire;
  logic                  rsp_free;
  logic                  walk_bit;
  logic [NODE_W-1:0]     walk_next;
  logic [NODE_W-1:0]     leaf_wide;
  logic [LEVELS-1:0]     fill_way;
  logic [NODE_W-1:0]     parent;
  logic                  last_step;
  logic [TAG_WIDTH-1:0]  key;
  logic                  ram_we;
  logic [LINE_W-1:0]     ram_wdata;
  logic [LINE_W-1:0]     ram_rdata;
  logic [TAG_WIDTH-1:0]  rd_tag;
  logic [2:0]            rd_state;
  logic                  rd_dirty;
  logic                  tag_hit;
  rsp_t                  fill_res;
  rsp_t                  hit_res;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  // one tree level per step
  assign walk_bit  = tree_bits[node[LEVELS-1:0]];
  assign walk_next = {node[LEVELS-1:0], walk_bit};
  assign last_step = (cnt == CNT_W'(LEVELS - 1));

  // leaf reached by the walk, folded back onto the real ways
  assign leaf_wide = {1'b0, walk_next[LEVELS-1:0]};
  always_comb begin
    if (leaf_wide >= NODE_W'(WAYS)) begin
      fill_way = LEVELS'(leaf_wide - NODE_W'(WAYS));
    end else begin
      fill_way = walk_next[LEVELS-1:0];
    end
  end

  assign parent = node >> 1;

  // line store: tag, coherence state and dirty bit per way
  assign key       = TAG_WIDTH'(item.tag);
  assign ram_we    = (state == S_FDATA);
  assign ram_wdata = {key, item.line_state, item.line_dirty};
  assign rd_tag    = ram_rdata[LINE_W-1:4];
  assign rd_state  = ram_rdata[3:1];
  assign rd_dirty  = ram_rdata[0];
  assign tag_hit   = (rd_tag == key);

  tplru_ram #(
    .WIDTH (LINE_W),
    .DEPTH (WAYS)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr),
    .wdata (ram_wdata),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  // response for a fill, old occupant only if it was valid
  always_comb begin
    fill_res              = '0;
    fill_res.victim_way   = 4'(ptr);
    if (way_valid[ptr]) begin
      fill_res.victim_valid = 1'b1;
      fill_res.victim_tag   = 32'(rd_tag);
      fill_res.victim_state = rd_state;
      fill_res.victim_dirty = rd_dirty;
    end
  end

  // response for an invalidate hit
  always_comb begin
    hit_res              = '0;
    hit_res.victim_valid = 1'b1;
    hit_res.victim_way   = 4'(ptr);
    hit_res.victim_tag   = 32'(rd_tag);
    hit_res.victim_state = rd_state;
    hit_res.victim_dirty = rd_dirty;
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tree_bits <= '0;
      way_valid <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req.mode == MODE_FILL) begin
              state <= S_WALK;
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_WALK: begin
          tree_bits[node[LEVELS-1:0]] <= ~walk_bit;
          if (last_step) begin
            state <= S_FREAD;
          end
        end
        S_FREAD: begin
          state <= S_FDATA;
        end
        S_FDATA: begin
          way_valid[ptr] <= 1'b1;
          state          <= S_DONE;
        end
        S_SRCH: begin
          if (way_valid[ptr]) begin
            state <= S_SCMP;
          end else if (ptr == '0) begin
            state <= S_DONE;
          end
        end
        S_SCMP: begin
          if (tag_hit) begin
            way_valid[ptr] <= 1'b0;
            state          <= S_PATH;
          end else if (ptr == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_SRCH;
          end
        end
        S_PATH: begin
          tree_bits[parent[LEVELS-1:0]] <= ~node[0];
          if (last_step) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          item <= req;
          node <= NODE_W'(1);
          cnt  <= '0;
          ptr  <= LEVELS'(WAYS - 1);
          res  <= '0;
        end
      end
      S_WALK: begin
        node <= walk_next;
        cnt  <= cnt + CNT_W'(1);
        if (last_step) begin
          ptr <= fill_way;
        end
      end
      S_FDATA: begin
        res <= fill_res;
      end
      S_SRCH: begin
        if (!way_valid[ptr] && ptr != '0) begin
          ptr <= ptr - LEVELS'(1);
        end
      end
      S_SCMP: begin
        if (tag_hit) begin
          res  <= hit_res;
          node <= {1'b1, ptr};
          cnt  <= '0;
        end else if (ptr != '0) begin
          ptr <= ptr - LEVELS'(1);
        end
      end
      S_PATH: begin
        node <= parent;
        cnt  <= cnt + CNT_W'(1);
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp <= res;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/tplru_check.sv @@
module tplru_check (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input tplru_pkg::req_t req,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input tplru_pkg::rsp_t rsp
);
  import tplru_pkg::*;

  // a stalled response item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response item changed while stalled");

  // nothing returned means empty payload fields
  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.victim_valid |->
      rsp.victim_tag == '0 && rsp.victim_state == '0 && rsp.victim_dirty == 1'b0)
    else $error("empty response carries line data");

  // a response item carries no unknown bits
  a_known_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !$isunknown(rsp))
    else $error("response item has unknown bits");

  // one item at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while an item is in flight");

  // a response never appears in the cycle after an acceptance
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid |=> !rsp_valid)
    else $error("response too early");

endmodule

bind tree_plru_way_replacer_top tplru_check u_tplru_check (.*);
